>>> rtl/r2fft_pkg.sv
`default_nettype none
// ============================================================================
// r2fft_pkg
// Shared types, constants and functions of the radix-2 FFT engine.
// ============================================================================
package r2fft_pkg;

    localparam int N_MAX  = 64;
    localparam int LG_MAX = 6;
    localparam int ADDR_W = 6;
    localparam int LG_MIN = 2;

    // one input item
    typedef struct packed {
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
    } t_sample;

    // one result item
    typedef struct packed {
        logic signed [31:0] bin_re;
        logic signed [31:0] bin_im;
        logic [5:0]         bin_index;
        logic               last_bin;
    } t_bin;

    // buffer word
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } t_twiddle;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD,
        ST_MRE,
        ST_MIM,
        ST_RND,
        ST_WRP,
        ST_WRM,
        ST_ORD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BF_IDLE,
        BF_MUL_RE,
        BF_MUL_IM,
        BF_ROUND
    } t_bf_op;

    typedef enum logic [1:0] {
        WS_LOAD,
        WS_TOP,
        WS_BOT
    } t_wsel;

    // sequencer to buffer / output register
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_wsel             wsel;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              out_load;
        logic [5:0]        out_index;
        logic              out_last;
    } t_seq_ctl;

    // sequencer to butterfly unit
    typedef struct packed {
        t_bf_op   op;
        t_twiddle w;
    } t_bf_ctl;

    // clamp the size register into the supported range
    function automatic logic [2:0] active_lg(input logic [2:0] sz);
        logic [2:0] l;
        l = sz;
        if (sz < 3'(LG_MIN)) l = 3'(LG_MIN);
        if (sz > 3'(LG_MAX)) l = 3'(LG_MAX);
        return l;
    endfunction

    // reverse the low lg bits of idx
    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] idx,
                                                  input logic [2:0] lg);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++) r[b] = idx[ADDR_W-1-b];
        return r >> (3'(LG_MAX) - lg);
    endfunction

    // quarter wave of cos, 32768 scale
    function automatic logic [16:0] qcos(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd32768;
            5'd1:    v = 17'd32610;
            5'd2:    v = 17'd32138;
            5'd3:    v = 17'd31357;
            5'd4:    v = 17'd30274;
            5'd5:    v = 17'd28899;
            5'd6:    v = 17'd27246;
            5'd7:    v = 17'd25330;
            5'd8:    v = 17'd23170;
            5'd9:    v = 17'd20788;
            5'd10:   v = 17'd18205;
            5'd11:   v = 17'd15447;
            5'd12:   v = 17'd12540;
            5'd13:   v = 17'd9512;
            5'd14:   v = 17'd6393;
            5'd15:   v = 17'd3212;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)       r = 16'sh7fff;
        else if (v < -18'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    // twiddle exp(-i*2*pi*k/64), Q1.15
    function automatic t_twiddle twiddle(input logic [4:0] k);
        logic signed [17:0] vr;
        logic signed [17:0] vi;
        t_twiddle t;
        if (k <= 5'd16) begin
            vr = signed'({1'b0, qcos(k)});
            vi = -signed'({1'b0, qcos(5'(5'd16 - k))});
        end else begin
            vr = -signed'({1'b0, qcos(5'(6'd32 - {1'b0, k}))});
            vi = -signed'({1'b0, qcos(5'(k - 5'd16))});
        end
        t.re = sat16(vr);
        t.im = sat16(vi);
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7fff_ffff)       r = 32'sh7fff_ffff;
        else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/radix2_fft_engine.sv
`default_nettype none
// Load: one item per cycle unless a size write waits, straight to its bit-reversed slot.
// Transform: each butterfly is read, multiplied (real, then imaginary half) and rounded
//   in one shared unit, then top and bottom each use the single buffer write port.
// Unload: buffer read, then output register (held on stall); no new frame until done.
// Synchronous active-low reset: back to loading, partial frame dropped, size 64;
// the buffer itself is not cleared.
// ============================================================================
// radix2_fft_engine
// In-place radix-2 decimation-in-time FFT over up to 64 complex samples,
// fixed point with 32-bit saturated data.
// ============================================================================
module radix2_fft_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire r2fft_pkg::t_sample i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output r2fft_pkg::t_bin         o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_data
);

    r2fft_pkg::t_seq_ctl ctl;
    r2fft_pkg::t_bf_ctl  bf_ctl;
    r2fft_pkg::t_cplx    r_mem [r2fft_pkg::N_MAX];
    r2fft_pkg::t_cplx    r_rd_a;
    r2fft_pkg::t_cplx    r_rd_b;
    r2fft_pkg::t_cplx    bf_top;
    r2fft_pkg::t_cplx    bf_bot;
    r2fft_pkg::t_cplx    wdata;
    r2fft_pkg::t_bin     r_bin;

    r2fft_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (ctl),
        .o_bf        (bf_ctl)
    );

    r2fft_bfly u_bfly (
        .i_clk (i_clk),
        .i_ctl (bf_ctl),
        .i_a   (r_rd_a),
        .i_x   (r_rd_b),
        .o_top (bf_top),
        .o_bot (bf_bot)
    );

    // write data select
    always_comb begin
        case (ctl.wsel)
            r2fft_pkg::WS_TOP: wdata = bf_top;
            r2fft_pkg::WS_BOT: wdata = bf_bot;
            default: begin
                wdata.re = {{16{i_in_data.sample_re[15]}}, i_in_data.sample_re};
                wdata.im = {{16{i_in_data.sample_im[15]}}, i_in_data.sample_im};
            end
        endcase
    end

    // work buffer: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (ctl.we) begin
            r_mem[ctl.waddr] <= wdata;
        end
        if (ctl.re) begin
            r_rd_a <= r_mem[ctl.raddr_a];
            r_rd_b <= r_mem[ctl.raddr_b];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_bin.bin_re    <= r_rd_a.re;
            r_bin.bin_im    <= r_rd_a.im;
            r_bin.bin_index <= ctl.out_index;
            r_bin.last_bin  <= ctl.out_last;
        end
    end

    assign o_out_data = r_bin;

endmodule
`default_nettype wire

>>> rtl/r2fft_bfly.sv
`default_nettype none
// ============================================================================
// r2fft_bfly
// Shared butterfly unit: two 16x32 multipliers forming one half of the
// complex product per cycle, round-to-nearest, and saturated sum/difference.
// ============================================================================
module r2fft_bfly (
    input  wire logic              i_clk,
    input  wire r2fft_pkg::t_bf_ctl i_ctl,
    input  wire r2fft_pkg::t_cplx  i_a,
    input  wire r2fft_pkg::t_cplx  i_x,
    output r2fft_pkg::t_cplx       o_top,
    output r2fft_pkg::t_cplx       o_bot
);

    logic signed [15:0] ma0;
    logic signed [15:0] ma1;
    logic signed [47:0] m0;
    logic signed [47:0] m1;
    logic signed [48:0] n_acc;
    logic signed [48:0] r_acc;
    logic signed [34:0] rnd;
    logic signed [34:0] r_pr;
    logic signed [34:0] r_pi;

    // operand select: real half uses wr*xr - wi*xi, imag half wi*xr + wr*xi
    always_comb begin
        if (i_ctl.op == r2fft_pkg::BF_MUL_RE) begin
            ma0 = i_ctl.w.re;
            ma1 = i_ctl.w.im;
        end else begin
            ma0 = i_ctl.w.im;
            ma1 = i_ctl.w.re;
        end
    end

    assign m0 = ma0 * i_x.re;
    assign m1 = ma1 * i_x.im;

    always_comb begin
        if (i_ctl.op == r2fft_pkg::BF_MUL_RE) n_acc = 49'(m0) - 49'(m1);
        else                                  n_acc = 49'(m0) + 49'(m1);
    end

    // round half up, drop 15 fraction bits
    assign rnd = 35'((50'(r_acc) + 50'sd16384) >>> 15);

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            r2fft_pkg::BF_MUL_RE: begin
                r_acc <= n_acc;
            end
            r2fft_pkg::BF_MUL_IM: begin
                r_pr  <= rnd;
                r_acc <= n_acc;
            end
            r2fft_pkg::BF_ROUND: begin
                r_pi <= rnd;
            end
            default: begin
            end
        endcase
    end

    // butterfly outputs
    assign o_top.re = r2fft_pkg::sat32(36'(i_a.re) + 36'(r_pr));
    assign o_top.im = r2fft_pkg::sat32(36'(i_a.im) + 36'(r_pi));
    assign o_bot.re = r2fft_pkg::sat32(36'(i_a.re) - 36'(r_pr));
    assign o_bot.im = r2fft_pkg::sat32(36'(i_a.im) - 36'(r_pi));

endmodule
`default_nettype wire

>>> rtl/r2fft_seq.sv
`default_nettype none
// ============================================================================
// r2fft_seq
// Sequencer: sample loading in bit-reversed order, butterfly schedule over
// stages, and bin unload with the output valid flag.
// ============================================================================
module r2fft_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_data,
    output r2fft_pkg::t_seq_ctl      o_ctl,
    output r2fft_pkg::t_bf_ctl       o_bf
);

    r2fft_pkg::t_state r_state;
    r2fft_pkg::t_state n_state;
    logic [6:0] r_cnt;
    logic [6:0] n_cnt;
    logic [2:0] r_stage;
    logic [2:0] n_stage;
    logic [4:0] r_bf;
    logic [4:0] n_bf;
    logic [5:0] r_k;
    logic [5:0] n_k;
    logic [2:0] r_size;
    logic [2:0] n_size;
    logic       r_ovalid;
    logic       n_ovalid;

    logic [2:0] lg;
    logic [6:0] n_len;
    logic [5:0] bf6;
    logic [5:0] span;
    logic [5:0] lmask;
    logic [5:0] addr_p;
    logic [5:0] addr_m;
    logic [5:0] grp;
    logic       in_acc;
    logic       cfg_acc;
    logic       out_free;
    logic       bf_last;
    logic       k_last;

    assign lg     = r2fft_pkg::active_lg(r_size);
    assign n_len  = 7'(1) << lg;

    // butterfly addressing: insert a zero at bit position stage
    assign bf6    = {1'b0, r_bf};
    assign span   = 6'(1) << r_stage;
    assign lmask  = span - 6'd1;
    assign addr_p = ((bf6 & ~lmask) << 1) | (bf6 & lmask);
    assign addr_m = addr_p | span;
    assign grp    = bf6 & lmask;

    assign bf_last  = ({2'b00, r_bf} == 7'((n_len >> 1) - 7'd1));
    assign k_last   = ({1'b0, r_k} == 7'(n_len - 7'd1));
    assign out_free = !r_ovalid || i_out_ready;

    // a pending size write goes first, the sample waits until it is taken
    assign o_in_ready  = (r_state == r2fft_pkg::ST_LOAD) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == r2fft_pkg::ST_LOAD);
    assign o_out_valid = r_ovalid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_stage = r_stage;
        n_bf    = r_bf;
        n_k     = r_k;
        n_size  = r_size;
        case (r_state)
            r2fft_pkg::ST_LOAD: begin
                if (cfg_acc) begin
                    n_size = i_cfg_data;
                    n_cnt  = 7'd0;
                end else if (in_acc) begin
                    if (r_cnt + 7'd1 == n_len) begin
                        n_cnt   = 7'd0;
                        n_stage = 3'd0;
                        n_bf    = 5'd0;
                        n_state = r2fft_pkg::ST_RD;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            r2fft_pkg::ST_RD:  n_state = r2fft_pkg::ST_MRE;
            r2fft_pkg::ST_MRE: n_state = r2fft_pkg::ST_MIM;
            r2fft_pkg::ST_MIM: n_state = r2fft_pkg::ST_RND;
            r2fft_pkg::ST_RND: n_state = r2fft_pkg::ST_WRP;
            r2fft_pkg::ST_WRP: n_state = r2fft_pkg::ST_WRM;
            r2fft_pkg::ST_WRM: begin
                if (bf_last) begin
                    n_bf = 5'd0;
                    if (r_stage == lg - 3'd1) begin
                        n_k     = 6'd0;
                        n_state = r2fft_pkg::ST_ORD;
                    end else begin
                        n_stage = r_stage + 3'd1;
                        n_state = r2fft_pkg::ST_RD;
                    end
                end else begin
                    n_bf    = r_bf + 5'd1;
                    n_state = r2fft_pkg::ST_RD;
                end
            end
            r2fft_pkg::ST_ORD: n_state = r2fft_pkg::ST_OUT;
            r2fft_pkg::ST_OUT: begin
                if (out_free) begin
                    if (k_last) begin
                        n_state = r2fft_pkg::ST_LOAD;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = r2fft_pkg::ST_ORD;
                    end
                end
            end
            default: n_state = r2fft_pkg::ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctl           = '0;
        o_ctl.wsel      = r2fft_pkg::WS_LOAD;
        o_bf.op         = r2fft_pkg::BF_IDLE;
        o_bf.w          = r2fft_pkg::twiddle(5'(grp << (3'(r2fft_pkg::LG_MAX - 1) - r_stage)));
        o_ctl.raddr_a   = addr_p;
        o_ctl.raddr_b   = addr_m;
        o_ctl.out_index = r_k;
        o_ctl.out_last  = k_last;
        case (r_state)
            r2fft_pkg::ST_LOAD: begin
                o_ctl.we    = in_acc && !cfg_acc;
                o_ctl.waddr = r2fft_pkg::bit_rev(r_cnt[5:0], lg);
                o_ctl.wsel  = r2fft_pkg::WS_LOAD;
            end
            r2fft_pkg::ST_RD:  o_ctl.re = 1'b1;
            r2fft_pkg::ST_MRE: o_bf.op  = r2fft_pkg::BF_MUL_RE;
            r2fft_pkg::ST_MIM: o_bf.op  = r2fft_pkg::BF_MUL_IM;
            r2fft_pkg::ST_RND: o_bf.op  = r2fft_pkg::BF_ROUND;
            r2fft_pkg::ST_WRP: begin
                o_ctl.we    = 1'b1;
                o_ctl.waddr = addr_p;
                o_ctl.wsel  = r2fft_pkg::WS_TOP;
            end
            r2fft_pkg::ST_WRM: begin
                o_ctl.we    = 1'b1;
                o_ctl.waddr = addr_m;
                o_ctl.wsel  = r2fft_pkg::WS_BOT;
            end
            r2fft_pkg::ST_ORD: begin
                o_ctl.re      = 1'b1;
                o_ctl.raddr_a = r_k;
            end
            r2fft_pkg::ST_OUT: begin
                o_ctl.raddr_a  = r_k;
                o_ctl.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_ctl.out_load)    n_ovalid = 1'b1;
        else if (i_out_ready)  n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= r2fft_pkg::ST_LOAD;
            r_cnt    <= 7'd0;
            r_stage  <= 3'd0;
            r_bf     <= 5'd0;
            r_k      <= 6'd0;
            r_size   <= 3'(r2fft_pkg::LG_MAX);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_stage  <= n_stage;
            r_bf     <= n_bf;
            r_k      <= n_k;
            r_size   <= n_size;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
`default_nettype wire

>>> rtl/r2fft_chk.sv
`default_nettype none
// ============================================================================
// r2fft_chk
// Port-level checks of the FFT engine, bound to the top level.
// ============================================================================
module r2fft_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire r2fft_pkg::t_bin    o_out_data,
    input wire logic               o_cfg_ready
);

    // reset leaves the block loading with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_cfg_ready && !o_out_valid)
        else $error("not idle after reset");

    // a stalled bin holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled bin changed");

    // while loading, only the last bin of the previous frame may be waiting
    a_load_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.last_bin)
        else $error("bin pending during load");

    // taking the last bin drains the output
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_bin |=> !o_out_valid)
        else $error("bin after last");

    // no input taken while bins are still being produced
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_bin |-> !o_in_ready && !o_cfg_ready)
        else $error("input taken during unload");

endmodule

bind radix2_fft_engine r2fft_chk u_chk (.*);
`default_nettype wire
